@@ rtl/core/stfs_pkg.sv @@
// Shared types, widths, register indexes and rounding tables of the flux smoother.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
package stfs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LIMIT_W    = 17;
  localparam int NB_COUNT   = 8;
  localparam int PART_W     = 18;
  localparam int SUM_W      = 20;
  localparam int NUMER_W    = SUM_W + 1;
  localparam int CNT_W      = 4;
  localparam int RECIP_W    = 21;
  localparam int PROD_W     = NUMER_W + RECIP_W;
  localparam int CFG_IDX_W  = 2;
  localparam int PIPE_DEPTH = 6;
  localparam int PEND_W     = 4;

  localparam int SHIFT_NARROW  = 16;
  localparam int SHIFT_WIDE_T  = 19;
  localparam int SHIFT_WIDE_ST = 21;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ST_MODE = 2'd0,
    REG_WIDE    = 2'd1,
    REG_T_LIMIT = 2'd2,
    REG_S_LIMIT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic               st_mode;
    logic               wide;
    logic [LIMIT_W-1:0] t_limit;
    logic [LIMIT_W-1:0] s_limit;
  } cfg_t;

  function automatic logic admitted(input logic [SAMPLE_W-1:0] s,
                                    input logic [SAMPLE_W-1:0] c,
                                    input logic [LIMIT_W-1:0] lim);
    logic [SAMPLE_W-1:0] diff;
    diff = (s > c) ? (s - c) : (c - s);
    return !lim[LIMIT_W-1] && (diff <= lim[SAMPLE_W-1:0]);
  endfunction

  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count,
                                               input logic wide,
                                               input logic st_mode);
    logic [RECIP_W-1:0] m;
    if (!wide) begin
      case (count)
        4'd1:    m = RECIP_W'(32767);
        4'd2:    m = RECIP_W'(16384);
        4'd3:    m = RECIP_W'(10923);
        4'd4:    m = RECIP_W'(8192);
        4'd5:    m = RECIP_W'(6554);
        4'd6:    m = RECIP_W'(5461);
        4'd7:    m = RECIP_W'(4681);
        4'd8:    m = RECIP_W'(4096);
        4'd9:    m = RECIP_W'(3641);
        4'd10:   m = RECIP_W'(3277);
        default: m = RECIP_W'(2979);
      endcase
    end else if (st_mode) begin
      case (count)
        4'd1:    m = RECIP_W'(1048576);
        4'd2:    m = RECIP_W'(524288);
        4'd3:    m = RECIP_W'(349525);
        4'd4:    m = RECIP_W'(262144);
        4'd5:    m = RECIP_W'(209715);
        4'd6:    m = RECIP_W'(174763);
        4'd7:    m = RECIP_W'(149797);
        4'd8:    m = RECIP_W'(131072);
        4'd9:    m = RECIP_W'(116508);
        4'd10:   m = RECIP_W'(104858);
        default: m = RECIP_W'(95325);
      endcase
    end else begin
      case (count)
        4'd1:    m = RECIP_W'(262144);
        4'd2:    m = RECIP_W'(131072);
        default: m = RECIP_W'(87381);
      endcase
    end
    return m;
  endfunction

endpackage

@@ rtl/core/stfs_scale.sv @@
// Reciprocal lookup and multiply that turn a rounded numerator into a scaled mean.
// Depends on stfs_pkg for widths, the configuration struct and the tables.
module stfs_scale (
  input  logic [stfs_pkg::NUMER_W-1:0] numer,
  input  logic [stfs_pkg::CNT_W-1:0]   count,
  input  stfs_pkg::cfg_t               cfg,
  output logic [stfs_pkg::PROD_W-1:0]  product
);

  logic [stfs_pkg::RECIP_W-1:0] m;

  assign m = stfs_pkg::recip(count, cfg.wide, cfg.st_mode);
  assign product = stfs_pkg::PROD_W'(numer) * stfs_pkg::PROD_W'(m);

endmodule

@@ rtl/core/spatiotemporal_flux_smoother.sv @@
// Top level of the spatio-temporal flux smoother: configuration registers and pipeline.
// Depends on stfs_pkg and stfs_scale.
//
// The block takes one word per clock and returns one word per clock while out_ready is
// high. A word passes six register stages on its way to out_pixel: input capture,
// admission compares, partial sums, final sum, multiply and output select. Every stage
// has its own valid bit and advances when it is empty or the stage after it advances,
// so bubbles close up under back pressure and the input stays ready while a finished
// word waits as long as any stage is empty; with all six stages full, in_ready follows
// out_ready. Configuration writes are always taken and should only be issued while no
// word is in flight.
module spatiotemporal_flux_smoother (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [stfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stfs_pkg::LIMIT_W-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [stfs_pkg::SAMPLE_W-1:0]   prev_pixel,
  input  logic [stfs_pkg::SAMPLE_W-1:0]   curr_pixel,
  input  logic [stfs_pkg::SAMPLE_W-1:0]   next_pixel,
  input  logic [stfs_pkg::SAMPLE_W-1:0]   n_up_left,
  input  logic [stfs_pkg::SAMPLE_W-1:0]   n_up,
  input  logic [stfs_pkg::SAMPLE_W-1:0]   n_up_right,
  input  logic [stfs_pkg::SAMPLE_W-1:0]   n_left,
  input  logic [stfs_pkg::SAMPLE_W-1:0]   n_right,
  input  logic [stfs_pkg::SAMPLE_W-1:0]   n_down_left,
  input  logic [stfs_pkg::SAMPLE_W-1:0]   n_down,
  input  logic [stfs_pkg::SAMPLE_W-1:0]   n_down_right,
  input  logic                            pass_through,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [stfs_pkg::SAMPLE_W-1:0]   out_pixel
);

  stfs_pkg::cfg_t cfg;
  logic [stfs_pkg::SAMPLE_W-1:0] smask;

  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  logic [stfs_pkg::SAMPLE_W-1:0] s1_prev, s1_curr, s1_next;
  logic [stfs_pkg::SAMPLE_W-1:0] s1_nb [stfs_pkg::NB_COUNT];
  logic                          s1_pass;

  logic [stfs_pkg::SAMPLE_W-1:0] s2_prev, s2_curr, s2_next;
  logic [stfs_pkg::SAMPLE_W-1:0] s2_nb [stfs_pkg::NB_COUNT];
  logic                          s2_adm_prev, s2_adm_next;
  logic [stfs_pkg::NB_COUNT-1:0] s2_adm_nb;
  logic                          s2_use;

  logic [stfs_pkg::PART_W-1:0]   s3_part_t, s3_part_a, s3_part_b;
  logic [stfs_pkg::CNT_W-1:0]    s3_count;
  logic [stfs_pkg::SAMPLE_W-1:0] s3_curr;
  logic                          s3_use;

  logic [stfs_pkg::NUMER_W-1:0]  s4_numer;
  logic [stfs_pkg::CNT_W-1:0]    s4_count;
  logic [stfs_pkg::SAMPLE_W-1:0] s4_curr;
  logic                          s4_use;

  logic [stfs_pkg::PROD_W-1:0]   s5_prod;
  logic [stfs_pkg::SAMPLE_W-1:0] s5_curr;
  logic                          s5_use;

  logic [stfs_pkg::SAMPLE_W-1:0] s6_pixel;

  logic                          flux;
  logic                          adm_prev, adm_next;
  logic [stfs_pkg::NB_COUNT-1:0] adm_nb;
  logic [stfs_pkg::SAMPLE_W-1:0] g_nb [stfs_pkg::NB_COUNT];
  logic [stfs_pkg::PART_W-1:0]   part_t, part_a, part_b;
  logic [stfs_pkg::CNT_W-1:0]    count;
  logic [stfs_pkg::SUM_W-1:0]    sum;
  logic [stfs_pkg::PROD_W-1:0]   product;
  logic [stfs_pkg::PROD_W-1:0]   shifted;
  logic [stfs_pkg::SAMPLE_W-1:0] mean;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.st_mode <= 1'b1;
      cfg.wide    <= 1'b0;
      cfg.t_limit <= stfs_pkg::LIMIT_W'(7);
      cfg.s_limit <= stfs_pkg::LIMIT_W'(7);
    end else if (cfg_valid) begin
      unique case (stfs_pkg::cfg_index_t'(cfg_index))
        stfs_pkg::REG_ST_MODE: cfg.st_mode <= cfg_data[0];
        stfs_pkg::REG_WIDE:    cfg.wide    <= cfg_data[0];
        stfs_pkg::REG_T_LIMIT: cfg.t_limit <= cfg_data;
        stfs_pkg::REG_S_LIMIT: cfg.s_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign smask = cfg.wide ? {stfs_pkg::SAMPLE_W{1'b1}}
                          : stfs_pkg::SAMPLE_W'(8'hFF);

  assign en6 = !v6 || out_ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_prev   <= prev_pixel & smask;
      s1_curr   <= curr_pixel & smask;
      s1_next   <= next_pixel & smask;
      s1_nb[0]  <= n_up_left & smask;
      s1_nb[1]  <= n_up & smask;
      s1_nb[2]  <= n_up_right & smask;
      s1_nb[3]  <= n_left & smask;
      s1_nb[4]  <= n_right & smask;
      s1_nb[5]  <= n_down_left & smask;
      s1_nb[6]  <= n_down & smask;
      s1_nb[7]  <= n_down_right & smask;
      s1_pass   <= pass_through;
    end
  end

  always_comb begin
    flux = ((s1_prev < s1_curr) && (s1_next < s1_curr)) ||
           ((s1_prev > s1_curr) && (s1_next > s1_curr));
    adm_prev = stfs_pkg::admitted(s1_prev, s1_curr, cfg.t_limit);
    adm_next = stfs_pkg::admitted(s1_next, s1_curr, cfg.t_limit);
    for (int i = 0; i < stfs_pkg::NB_COUNT; i++) begin
      adm_nb[i] = cfg.st_mode && stfs_pkg::admitted(s1_nb[i], s1_curr, cfg.s_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_prev     <= s1_prev;
      s2_curr     <= s1_curr;
      s2_next     <= s1_next;
      s2_nb       <= s1_nb;
      s2_adm_prev <= adm_prev;
      s2_adm_next <= adm_next;
      s2_adm_nb   <= adm_nb;
      s2_use      <= flux && !s1_pass;
    end
  end

  always_comb begin
    for (int i = 0; i < stfs_pkg::NB_COUNT; i++) begin
      g_nb[i] = s2_adm_nb[i] ? s2_nb[i] : '0;
    end
    part_t = stfs_pkg::PART_W'(s2_curr)
           + stfs_pkg::PART_W'(s2_adm_prev ? s2_prev : '0)
           + stfs_pkg::PART_W'(s2_adm_next ? s2_next : '0);
    part_a = stfs_pkg::PART_W'(g_nb[0]) + stfs_pkg::PART_W'(g_nb[1])
           + stfs_pkg::PART_W'(g_nb[2]) + stfs_pkg::PART_W'(g_nb[3]);
    part_b = stfs_pkg::PART_W'(g_nb[4]) + stfs_pkg::PART_W'(g_nb[5])
           + stfs_pkg::PART_W'(g_nb[6]) + stfs_pkg::PART_W'(g_nb[7]);
    count = stfs_pkg::CNT_W'(1) + stfs_pkg::CNT_W'(s2_adm_prev)
          + stfs_pkg::CNT_W'(s2_adm_next);
    for (int i = 0; i < stfs_pkg::NB_COUNT; i++) begin
      count = count + stfs_pkg::CNT_W'(s2_adm_nb[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_part_t <= part_t;
      s3_part_a <= part_a;
      s3_part_b <= part_b;
      s3_count  <= count;
      s3_curr   <= s2_curr;
      s3_use    <= s2_use;
    end
  end

  assign sum = stfs_pkg::SUM_W'(s3_part_t) + stfs_pkg::SUM_W'(s3_part_a)
             + stfs_pkg::SUM_W'(s3_part_b);

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_numer <= {sum, 1'b0} + stfs_pkg::NUMER_W'(s3_count);
      s4_count <= s3_count;
      s4_curr  <= s3_curr;
      s4_use   <= s3_use;
    end
  end

  stfs_scale u_scale (
    .numer   (s4_numer),
    .count   (s4_count),
    .cfg     (cfg),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_prod <= product;
      s5_curr <= s4_curr;
      s5_use  <= s4_use;
    end
  end

  always_comb begin
    if (!cfg.wide) begin
      shifted = s5_prod >> stfs_pkg::SHIFT_NARROW;
    end else if (cfg.st_mode) begin
      shifted = s5_prod >> stfs_pkg::SHIFT_WIDE_ST;
    end else begin
      shifted = s5_prod >> stfs_pkg::SHIFT_WIDE_T;
    end
    mean = shifted[stfs_pkg::SAMPLE_W-1:0] & smask;
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_pixel <= s5_use ? mean : s5_curr;
    end
  end

  assign out_valid = v6;
  assign out_pixel = s6_pixel;

endmodule

@@ rtl/core/stfs_checker.sv @@
// Port-level checks of the flux smoother and the bind that attaches them.
// Depends on stfs_pkg and on the port names of spatiotemporal_flux_smoother.
module stfs_port_checks (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [stfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [stfs_pkg::LIMIT_W-1:0]    cfg_data,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [stfs_pkg::SAMPLE_W-1:0]   out_pixel
);

  logic                          wide;
  logic [stfs_pkg::PEND_W-1:0]   pending;
  logic                          in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide <= 1'b0;
    end else if (cfg_valid && cfg_ready &&
                 (stfs_pkg::cfg_index_t'(cfg_index) == stfs_pkg::REG_WIDE)) begin
      wide <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + stfs_pkg::PEND_W'(in_fire) - stfs_pkg::PEND_W'(out_fire);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel))
    else $error("Output word changed or dropped while stalled.");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("Output word shown with no input word outstanding.");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= stfs_pkg::PEND_W'(stfs_pkg::PIPE_DEPTH))
    else $error("More words in flight than the pipeline holds.");

  a_narrow: assert property (@(posedge clk) disable iff (rst)
    out_valid && !wide |-> out_pixel[stfs_pkg::SAMPLE_W-1:8] == '0)
    else $error("Narrow sample mode produced a word wider than eight bits.");

endmodule

bind spatiotemporal_flux_smoother stfs_port_checks u_checker (.*);

@@ dv/stfs_checker.sv @@
`timescale 1ns / 100ps
// Checker for the flux smoother: follows the register writes, predicts each pixel
// and compares every accepted output word with the oldest prediction.
// Depends on stfs_pkg for widths, shift amounts and register indexes.
module stfs_checker
  import stfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]  cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [SAMPLE_W-1:0] prev_pixel,
  input  logic [SAMPLE_W-1:0] curr_pixel,
  input  logic [SAMPLE_W-1:0] next_pixel,
  input  logic [SAMPLE_W-1:0] n_up_left,
  input  logic [SAMPLE_W-1:0] n_up,
  input  logic [SAMPLE_W-1:0] n_up_right,
  input  logic [SAMPLE_W-1:0] n_left,
  input  logic [SAMPLE_W-1:0] n_right,
  input  logic [SAMPLE_W-1:0] n_down_left,
  input  logic [SAMPLE_W-1:0] n_down,
  input  logic [SAMPLE_W-1:0] n_down_right,
  input  logic                pass_through,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [SAMPLE_W-1:0] out_pixel,
  output int                  fail_count,
  output int                  pending
);

  localparam longint unsigned NARROW_RECIP [12] = '{
    0, 32767, 16384, 10923, 8192, 6554, 5461, 4681, 4096, 3641, 3277, 2979
  };
  localparam longint unsigned WIDE_T_RECIP [4] = '{0, 262144, 131072, 87381};
  localparam longint unsigned WIDE_ST_RECIP [12] = '{
    0, 1048576, 524288, 349525, 262144, 209715, 174763, 149797, 131072, 116508,
    104858, 95325
  };

  logic                      st_mode;
  logic                      wide;
  logic signed [LIMIT_W-1:0] t_lim;
  logic signed [LIMIT_W-1:0] s_lim;
  logic [SAMPLE_W-1:0]       expected_pixels [$];
  logic [SAMPLE_W-1:0]       oldest;

  function automatic bit within_limit(input logic [SAMPLE_W-1:0] a,
                                      input logic [SAMPLE_W-1:0] b,
                                      input logic signed [LIMIT_W-1:0] lim);
    int diff;
    diff = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return (lim >= 0) && (diff <= int'(lim));
  endfunction

  function automatic logic [SAMPLE_W-1:0] smooth_pixel(
      input logic [SAMPLE_W-1:0] prev_s,
      input logic [SAMPLE_W-1:0] curr_s,
      input logic [SAMPLE_W-1:0] next_s,
      input logic [NB_COUNT-1:0][SAMPLE_W-1:0] nbrs,
      input logic pass);
    logic [SAMPLE_W-1:0] mask;
    logic [SAMPLE_W-1:0] p;
    logic [SAMPLE_W-1:0] c;
    logic [SAMPLE_W-1:0] n;
    logic [SAMPLE_W-1:0] nb;
    int unsigned         total;
    int unsigned         count;
    longint unsigned     m;
    longint unsigned     scaled;
    int                  shift;
    int                  i;
    mask = wide ? 16'hFFFF : 16'h00FF;
    p = prev_s & mask;
    c = curr_s & mask;
    n = next_s & mask;
    if (pass || !((p < c && n < c) || (p > c && n > c))) return c;
    total = c;
    count = 1;
    if (within_limit(p, c, t_lim)) begin
      total += p;
      count++;
    end
    if (within_limit(n, c, t_lim)) begin
      total += n;
      count++;
    end
    if (st_mode) begin
      for (i = 0; i < NB_COUNT; i++) begin
        nb = nbrs[i] & mask;
        if (within_limit(nb, c, s_lim)) begin
          total += nb;
          count++;
        end
      end
    end
    if (!wide) begin
      m = NARROW_RECIP[count];
      shift = SHIFT_NARROW;
    end else if (st_mode) begin
      m = WIDE_ST_RECIP[count];
      shift = SHIFT_WIDE_ST;
    end else begin
      m = WIDE_T_RECIP[count];
      shift = SHIFT_WIDE_T;
    end
    scaled = (64'(total) * 2 + count) * m;
    scaled = scaled >> shift;
    return scaled[SAMPLE_W-1:0] & mask;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      st_mode <= 1'b1;
      wide <= 1'b0;
      t_lim <= 17'sd7;
      s_lim <= 17'sd7;
      expected_pixels.delete();
      pending <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ST_MODE: st_mode <= cfg_data[0];
          REG_WIDE:    wide <= cfg_data[0];
          REG_T_LIMIT: t_lim <= cfg_data;
          REG_S_LIMIT: s_lim <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_pixels.push_back(smooth_pixel(prev_pixel, curr_pixel, next_pixel,
            {n_down_right, n_down, n_down_left, n_right, n_left, n_up_right, n_up,
             n_up_left}, pass_through));
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: out_pixel expected none, got %h", $time, out_pixel);
          fail_count <= fail_count + 1;
        end else begin
          oldest = expected_pixels.pop_front();
          if (oldest !== out_pixel) begin
            $display("%0t: out_pixel expected %h, got %h", $time, oldest, out_pixel);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_pixels.size();
    end
  end

endmodule

@@ dv/spatiotemporal_flux_smoother_test.sv @@
`timescale 1ns / 100ps
// Top of the flux smoother testbench: clock, reset, register settings, pixel words and
// output back pressure. Depends on stfs_pkg, the block and stfs_checker.
module spatiotemporal_flux_smoother_test;
  import stfs_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0]               prev_s;
    logic [SAMPLE_W-1:0]               curr_s;
    logic [SAMPLE_W-1:0]               next_s;
    logic [NB_COUNT-1:0][SAMPLE_W-1:0] nbrs;
    logic                              pass;
  } pixel_word_t;

  typedef struct packed {
    bit st_mode;
    bit wide;
    int t_lim;
    int s_lim;
  } smoother_setting_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  prev_pixel;
  logic [SAMPLE_W-1:0]  curr_pixel;
  logic [SAMPLE_W-1:0]  next_pixel;
  logic [SAMPLE_W-1:0]  n_up_left;
  logic [SAMPLE_W-1:0]  n_up;
  logic [SAMPLE_W-1:0]  n_up_right;
  logic [SAMPLE_W-1:0]  n_left;
  logic [SAMPLE_W-1:0]  n_right;
  logic [SAMPLE_W-1:0]  n_down_left;
  logic [SAMPLE_W-1:0]  n_down;
  logic [SAMPLE_W-1:0]  n_down_right;
  logic                 pass_through;
  logic                 out_valid;
  logic                 out_ready;
  logic [SAMPLE_W-1:0]  out_pixel;
  int                   fail_count;
  int                   pending;

  pixel_word_t word_q;
  bit          no_idle;
  int          hold_left;
  bit          ready_level;

  assign prev_pixel   = word_q.prev_s;
  assign curr_pixel   = word_q.curr_s;
  assign next_pixel   = word_q.next_s;
  assign n_up_left    = word_q.nbrs[0];
  assign n_up         = word_q.nbrs[1];
  assign n_up_right   = word_q.nbrs[2];
  assign n_left       = word_q.nbrs[3];
  assign n_right      = word_q.nbrs[4];
  assign n_down_left  = word_q.nbrs[5];
  assign n_down       = word_q.nbrs[6];
  assign n_down_right = word_q.nbrs[7];
  assign pass_through = word_q.pass;

  spatiotemporal_flux_smoother u_top (.*);

  stfs_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (hold_left == 0) begin
      ready_level = no_idle || ($urandom_range(0, 2) != 0);
      hold_left = ready_level ? $urandom_range(1, 20) : 1 + idle_len();
    end else begin
      hold_left--;
    end
    out_ready <= ready_level;
  end

  function automatic int clamp_sample(input int v, input int top);
    return (v < 0) ? 0 : ((v > top) ? top : v);
  endfunction

  function automatic int span_for(input int lim, input int top);
    if (lim < 0) return 20;
    return (lim + 3 > top) ? top : lim + 3;
  endfunction

  function automatic int random_limit();
    case ($urandom_range(0, 5))
      0: return -1;
      1: return -int'($urandom_range(2, 65536));
      2: return 0;
      3: return $urandom_range(1, 30);
      4: return $urandom_range(31, 65534);
      default: return 65535;
    endcase
  endfunction

  // Most words are shaped around the current limits so that the flux and
  // admission decisions both go either way.
  function automatic pixel_word_t random_word(input smoother_setting_t s);
    pixel_word_t w;
    int          top;
    int          c;
    int          kind;
    int          tspan;
    int          sspan;
    int          dir;
    int          i;
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      w.prev_s = SAMPLE_W'($urandom);
      w.curr_s = SAMPLE_W'($urandom);
      w.next_s = SAMPLE_W'($urandom);
      for (i = 0; i < NB_COUNT; i++) w.nbrs[i] = SAMPLE_W'($urandom);
      w.pass = 1'($urandom_range(0, 1));
      return w;
    end
    top = s.wide ? 65535 : 255;
    c = $urandom_range(0, top);
    tspan = span_for(s.t_lim, top);
    sspan = span_for(s.s_lim, top);
    if (kind < 70) begin
      dir = (c == 0) ? 1 : ((c == top) ? -1 : ($urandom_range(0, 1) ? 1 : -1));
      w.prev_s = SAMPLE_W'(clamp_sample(c + dir * int'($urandom_range(1, tspan)), top));
      w.next_s = SAMPLE_W'(clamp_sample(c + dir * int'($urandom_range(1, tspan)), top));
    end else begin
      w.prev_s = SAMPLE_W'(clamp_sample(c - int'($urandom_range(0, tspan)), top));
      w.next_s = SAMPLE_W'(clamp_sample(c + int'($urandom_range(0, tspan)), top));
      if ($urandom_range(0, 1)) {w.prev_s, w.next_s} = {w.next_s, w.prev_s};
    end
    w.curr_s = SAMPLE_W'(c);
    for (i = 0; i < NB_COUNT; i++) begin
      if ($urandom_range(0, 3) != 0)
        w.nbrs[i] = SAMPLE_W'(clamp_sample(c + int'($urandom_range(0, 2 * sspan)) - sspan,
                                           top));
      else
        w.nbrs[i] = SAMPLE_W'($urandom);
    end
    if (!s.wide) begin
      w.prev_s[15:8] = 8'($urandom);
      w.curr_s[15:8] = 8'($urandom);
      w.next_s[15:8] = 8'($urandom);
      for (i = 0; i < NB_COUNT; i++) w.nbrs[i][15:8] = 8'($urandom);
    end
    w.pass = ($urandom_range(0, 9) == 0);
    return w;
  endfunction

  task automatic send_word(input pixel_word_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_q <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int value);
    cfg_index <= idx;
    cfg_data <= value[LIMIT_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Registers change only once every word in flight has come out.
  task automatic apply_setting(input smoother_setting_t s);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    write_reg(REG_ST_MODE, int'(s.st_mode));
    write_reg(REG_WIDE, int'(s.wide));
    write_reg(REG_T_LIMIT, s.t_lim);
    write_reg(REG_S_LIMIT, s.s_lim);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    smoother_setting_t s;
    int                ph;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ST_MODE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    word_q <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(pixel_word_t'{16'd0, 16'd0, 16'd0, '0, 1'b0});
    send_word(pixel_word_t'{'1, '1, '1, '1, 1'b0});
    send_word(pixel_word_t'{16'd95, 16'd100, 16'd97,
        {16'd93, 16'd100, 16'd107, 16'd108, 16'd92, 16'd101, 16'd99, 16'd100}, 1'b0});
    send_word(pixel_word_t'{16'd110, 16'd100, 16'd104, {8{16'd96}}, 1'b0});
    send_word(pixel_word_t'{16'd95, 16'd100, 16'd97, {8{16'd100}}, 1'b1});
    send_word(pixel_word_t'{16'd100, 16'd100, 16'd90, {8{16'd99}}, 1'b0});
    send_word(pixel_word_t'{16'd90, 16'd100, 16'd110, {8{16'd101}}, 1'b0});
    send_word(pixel_word_t'{16'hA15F, 16'h3C64, 16'hFF60, {8{16'h7766}}, 1'b0});
    send_word(pixel_word_t'{16'd250, 16'd255, 16'd252, {8{16'd255}}, 1'b0});
    send_word(pixel_word_t'{16'd3, 16'd0, 16'd5,
        {16'd0, 16'd7, 16'd8, 16'd255, 16'd1, 16'd2, 16'd6, 16'd0}, 1'b0});
    send_word(pixel_word_t'{16'h00FF, 16'h0000, 16'h00FF, '1, 1'b0});

    apply_setting(smoother_setting_t'{1'b0, 1'b0, 7, 7});
    send_word(pixel_word_t'{16'd120, 16'd127, 16'd121, '1, 1'b0});
    send_word(pixel_word_t'{16'd140, 16'd127, 16'd200, '0, 1'b0});
    send_word(pixel_word_t'{16'd120, 16'd127, 16'd121, '1, 1'b1});

    apply_setting(smoother_setting_t'{1'b1, 1'b1, 7, 7});
    send_word(pixel_word_t'{16'hFFF9, 16'hFFFF, 16'hFFFA, {8{16'hFFFC}}, 1'b0});
    send_word(pixel_word_t'{16'h0006, 16'h0000, 16'h0100, {8{16'h0003}}, 1'b0});
    send_word(pixel_word_t'{16'h1234, 16'h8000, 16'h7FFF, '1, 1'b0});

    apply_setting(smoother_setting_t'{1'b0, 1'b1, 7, 7});
    send_word(pixel_word_t'{16'hFFF9, 16'hFFFF, 16'hFFFA, '0, 1'b0});
    send_word(pixel_word_t'{16'h0007, 16'h0000, 16'h0002, '1, 1'b0});

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: s = smoother_setting_t'{1'b1, 1'b0, 0, 0};
        1: s = smoother_setting_t'{1'b1, 1'b1, 65535, 65535};
        2: s = smoother_setting_t'{1'b0, 1'b1, 300, -1};
        3: s = smoother_setting_t'{1'b1, 1'b0, -1, -1};
        4: s = smoother_setting_t'{1'b1, 1'b1, -65536, 40};
        5: s = smoother_setting_t'{1'b0, 1'b0, 65535, 3};
        default: s = smoother_setting_t'{1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)), random_limit(), random_limit()};
      endcase
      apply_setting(s);
      no_idle <= (ph == 6);
      repeat (150) send_word(random_word(s));
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
